// ===== hw/rtl/knn_patch_block_matcher_unit_macros.svh =====
// assertion macros for the rtl files, included by kpm_ctrl
`ifndef KNN_PATCH_BLOCK_MATCHER_UNIT_MACROS_SVH
`define KNN_PATCH_BLOCK_MATCHER_UNIT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define KPM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define KPM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/kpm_pkg.sv =====
// ----------------------------------------------------------------------------
// kpm_pkg
// types and constants shared by the patch matcher files
// ----------------------------------------------------------------------------
package kpm_pkg;
    localparam int DEF_MAX_WIDTH = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_BLOCK = 16;
    localparam int DEF_MAX_CAND = 16;

    localparam int CFG_W = 9;
    localparam int DIST_W = 24;
    localparam int PADDR_W = 5;

    localparam logic [2:0] REG_WIDTH = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_BLOCK = 3'd2;
    localparam logic [2:0] REG_CAND = 3'd3;
    localparam logic [2:0] REG_RADIUS = 3'd4;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic clear;
        logic load_win;
        logic first_pix;
        logic step_pix;
        logic acc_en;
        logic ins_check;
        logic ins_step;
        logic next_cand;
        logic out_load;
        logic out_next;
    } t_cmd;

    typedef struct packed {
        logic valid_ref;
        logic win_empty;
        logic pix_last;
        logic cand_last;
        logic ins_done;
        logic ins_skip;
        logic out_last;
    } t_sts;
endpackage

// ===== hw/rtl/knn_patch_block_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// knn_patch_block_matcher_unit
// k nearest patch search over a stored greyscale image
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  input   | i_valid, o_stall, func/pos_x/pos_y/pixel  | in
//  result  | o_valid, i_stall, cand_x/y/distance/flags | out
//  config  | psel/penable/pwrite/paddr/pwdata/prdata   | apb
// pixel write: stored when accepted, if inside MAX_WIDTH by MAX_HEIGHT
// query: per window position the B*B pixel pairs are fetched and accumulated, then
//   the distance is inserted into the sorted list from the tail; then K results
// synchronous active low reset restores register defaults; image undefined
// results held while i_stall is high; no input taken during a query
module knn_patch_block_matcher_unit #(
    parameter int MAX_WIDTH = kpm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = kpm_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_BLOCK = kpm_pkg::DEF_MAX_BLOCK,
    parameter int MAX_CANDIDATES = kpm_pkg::DEF_MAX_CAND
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_func,
    input  logic [7:0]                     i_pos_x,
    input  logic [7:0]                     i_pos_y,
    input  logic [7:0]                     i_pixel_value,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [8:0]                     o_cand_x,
    output logic [8:0]                     o_cand_y,
    output logic [kpm_pkg::DIST_W-1:0]     o_match_distance,
    output logic                           o_filled,
    output logic                           o_last,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kpm_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import kpm_pkg::*;

    logic [CFG_W-1:0] r_width, r_height, r_radius;
    logic [4:0] r_block, r_cand;
    logic wr;
    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 9'd256;
            r_height <= 9'd256;
            r_block <= 5'd8;
            r_cand <= 5'd16;
            r_radius <= 9'd256;
        end else if (wr && paddr[1:0] == 2'b00) begin
            case (paddr[4:2])
                REG_WIDTH: r_width <= pwdata[8:0];
                REG_HEIGHT: r_height <= pwdata[8:0];
                REG_BLOCK: r_block <= pwdata[4:0];
                REG_CAND: r_cand <= pwdata[4:0];
                REG_RADIUS: r_radius <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_WIDTH: prdata = {23'd0, r_width};
            REG_HEIGHT: prdata = {23'd0, r_height};
            REG_BLOCK: prdata = {27'd0, r_block};
            REG_CAND: prdata = {27'd0, r_cand};
            REG_RADIUS: prdata = {23'd0, r_radius};
            default: prdata = '0;
        endcase
    end

    t_cmd cmd;
    t_sts sts;
    logic wr_en;

    kpm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_func(i_func), .o_wr_en(wr_en), .o_valid(o_valid), .i_stall(i_stall),
        .o_cmd(cmd), .i_sts(sts)
    );

    kpm_datapath #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_BLOCK(MAX_BLOCK), .MAX_CANDIDATES(MAX_CANDIDATES)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts), .i_wr_en(wr_en),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pixel_value(i_pixel_value),
        .i_width(r_width), .i_height(r_height), .i_block(r_block), .i_cand(r_cand),
        .i_radius(r_radius), .o_cand_x(o_cand_x), .o_cand_y(o_cand_y),
        .o_match_distance(o_match_distance), .o_filled(o_filled), .o_last(o_last)
    );
endmodule

// ===== hw/rtl/kpm_datapath.sv =====
// ----------------------------------------------------------------------------
// kpm_datapath
// image memory, window walk, squared difference accumulator and sorted list
// ----------------------------------------------------------------------------
module kpm_datapath #(
    parameter int MAX_WIDTH = kpm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = kpm_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_BLOCK = kpm_pkg::DEF_MAX_BLOCK,
    parameter int MAX_CANDIDATES = kpm_pkg::DEF_MAX_CAND
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kpm_pkg::t_cmd                 i_cmd,
    output kpm_pkg::t_sts                 o_sts,
    input  logic                          i_wr_en,
    input  logic [7:0]                    i_pos_x,
    input  logic [7:0]                    i_pos_y,
    input  logic [7:0]                    i_pixel_value,
    input  logic [kpm_pkg::CFG_W-1:0]     i_width,
    input  logic [kpm_pkg::CFG_W-1:0]     i_height,
    input  logic [4:0]                    i_block,
    input  logic [4:0]                    i_cand,
    input  logic [kpm_pkg::CFG_W-1:0]     i_radius,
    output logic [8:0]                    o_cand_x,
    output logic [8:0]                    o_cand_y,
    output logic [kpm_pkg::DIST_W-1:0]    o_match_distance,
    output logic                          o_filled,
    output logic                          o_last
);
    import kpm_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int BW = $clog2(MAX_BLOCK + 1);
    localparam int KW = $clog2(MAX_CANDIDATES + 1);
    localparam int SW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int CW = 14;
    localparam int AW = 16 + 2 * BW;

    // clamped configuration (radius not clamped), widened to 14 bits
    logic [CW-1:0] w_c, h_c, b_c, k_c, r_c;
    always_comb begin
        w_c = (i_width == '0) ? CW'(1) :
              ({5'd0, i_width} > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : {5'd0, i_width};
        h_c = (i_height == '0) ? CW'(1) :
              ({5'd0, i_height} > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : {5'd0, i_height};
        b_c = (i_block == '0) ? CW'(1) :
              ({9'd0, i_block} > CW'(MAX_BLOCK)) ? CW'(MAX_BLOCK) : {9'd0, i_block};
        k_c = (i_cand == '0) ? CW'(1) :
              ({9'd0, i_cand} > CW'(MAX_CANDIDATES)) ? CW'(MAX_CANDIDATES) : {9'd0, i_cand};
        r_c = {5'd0, i_radius};
    end

    logic [CW-1:0] r_qx, r_qy, r_x0, r_x1, r_y1, r_sx, r_sy, r_b;
    logic [BW-1:0] r_ix, r_iy;
    logic [KW-1:0] r_k;

    logic [CW-1:0] xlim, ylim, x0, y0, x1, y1, qx, qy;
    always_comb begin
        qx = {6'd0, i_pos_x};
        qy = {6'd0, i_pos_y};
        xlim = w_c - b_c + CW'(1);
        ylim = h_c - b_c + CW'(1);
        x0 = (qx > r_c) ? qx - r_c : '0;
        y0 = (qy > r_c) ? qy - r_c : '0;
        x1 = (qx + r_c < xlim) ? qx + r_c : xlim;
        y1 = (qy + r_c < ylim) ? qy + r_c : ylim;
    end

    assign o_sts.valid_ref = (b_c <= w_c) && (b_c <= h_c) &&
                             (qx <= w_c - b_c) && (qy <= h_c - b_c);
    assign o_sts.win_empty = (x0 >= x1) || (y0 >= y1);
    assign o_sts.pix_last = ({{(CW-BW){1'b0}}, r_ix} == r_b - CW'(1)) &&
                            ({{(CW-BW){1'b0}}, r_iy} == r_b - CW'(1));
    assign o_sts.cand_last = (r_sx + CW'(1) >= r_x1) && (r_sy + CW'(1) >= r_y1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_win) begin
            r_qx <= qx;
            r_qy <= qy;
            r_x0 <= x0;
            r_x1 <= x1;
            r_y1 <= y1;
            r_sx <= x0;
            r_sy <= y0;
            r_b <= b_c;
            r_k <= k_c[KW-1:0];
        end else if (i_cmd.next_cand) begin
            if (r_sx + CW'(1) >= r_x1) begin
                r_sx <= r_x0;
                r_sy <= r_sy + CW'(1);
            end else begin
                r_sx <= r_sx + CW'(1);
            end
        end
        if (i_cmd.load_win || i_cmd.first_pix) begin
            r_ix <= '0;
            r_iy <= '0;
        end else if (i_cmd.step_pix) begin
            if ({{(CW-BW){1'b0}}, r_ix} == r_b - CW'(1)) begin
                r_ix <= '0;
                r_iy <= r_iy + BW'(1);
            end else begin
                r_ix <= r_ix + BW'(1);
            end
        end
    end

    // image memory, two read ports, one write port
    logic [7:0] mem [2**(XW+YW)];
    logic [XW+YW-1:0] ca, ra;
    logic [CW-1:0] cx, cy, rx, ry;
    logic [7:0] r_pc, r_pr;
    always_comb begin
        cx = r_sx + {{(CW-BW){1'b0}}, r_ix};
        cy = r_sy + {{(CW-BW){1'b0}}, r_iy};
        rx = r_qx + {{(CW-BW){1'b0}}, r_ix};
        ry = r_qy + {{(CW-BW){1'b0}}, r_iy};
        ca = {cy[YW-1:0], cx[XW-1:0]};
        ra = {ry[YW-1:0], rx[XW-1:0]};
    end

    logic wr_ok;
    assign wr_ok = ({6'd0, i_pos_x} < CW'(MAX_WIDTH)) && ({6'd0, i_pos_y} < CW'(MAX_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_ok) begin
            mem[{qy[YW-1:0], qx[XW-1:0]}] <= i_pixel_value;
        end
        r_pc <= mem[ca];
        r_pr <= mem[ra];
    end

    // squared difference accumulator
    logic signed [8:0] diff;
    logic signed [17:0] prod;
    logic [15:0] sq;
    logic [AW-1:0] r_acc;
    assign diff = $signed({1'b0, r_pc}) - $signed({1'b0, r_pr});
    assign prod = diff * diff;
    assign sq = prod[15:0];
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_win || i_cmd.first_pix) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + AW'(sq);
        end
    end

    // sorted list, insertion walks from the tail one slot a cycle
    logic [AW-1:0] r_dist [MAX_CANDIDATES];
    logic [CW-1:0] r_px [MAX_CANDIDATES];
    logic [CW-1:0] r_py [MAX_CANDIDATES];
    logic [MAX_CANDIDATES-1:0] r_val;
    logic [KW-1:0] r_ins;
    logic [AW-1:0] r_nd;
    logic [CW-1:0] r_nx, r_ny;
    logic [SW-1:0] tail, ip, im;
    logic prev_gt;
    assign tail = SW'(r_k - KW'(1));
    assign ip = r_ins[SW-1:0];
    assign im = SW'(r_ins - KW'(1));
    assign prev_gt = (r_ins != '0) && (!r_val[im] || r_dist[im] > r_nd);

    assign o_sts.ins_skip = r_val[tail] && (r_dist[tail] <= r_acc);
    assign o_sts.ins_done = !prev_gt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_val <= '0;
        end else if (i_cmd.ins_step) begin
            r_val[ip] <= 1'b1;
            if (prev_gt) begin
                r_val[ip] <= r_val[im];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_check) begin
            r_ins <= r_k - KW'(1);
            r_nd <= r_acc;
            r_nx <= r_sx;
            r_ny <= r_sy;
        end else if (i_cmd.ins_step) begin
            if (prev_gt) begin
                r_dist[ip] <= r_dist[im];
                r_px[ip] <= r_px[im];
                r_py[ip] <= r_py[im];
                r_ins <= r_ins - KW'(1);
            end else begin
                r_dist[ip] <= r_nd;
                r_px[ip] <= r_nx;
                r_py[ip] <= r_ny;
            end
        end
    end

    // output slot index; outputs are read combinationally from the list
    logic [KW-1:0] r_os;
    logic [SW-1:0] os;
    assign os = r_os[SW-1:0];
    assign o_sts.out_last = (r_os + KW'(1) == r_k);
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_os <= '0;
        end else if (i_cmd.out_next) begin
            r_os <= r_os + KW'(1);
        end
    end

    always_comb begin
        o_filled = r_val[os];
        o_last = (r_os + KW'(1) == r_k);
        o_cand_x = '0;
        o_cand_y = '0;
        o_match_distance = '0;
        if (r_val[os]) begin
            o_cand_x = 9'(r_px[os] + CW'(1));
            o_cand_y = 9'(r_py[os] + CW'(1));
            o_match_distance = (r_dist[os] > AW'(24'hFFFFFF)) ? 24'hFFFFFF
                                                              : DIST_W'(r_dist[os]);
        end
    end
endmodule

// ===== hw/rtl/kpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// kpm_ctrl
// sequencer for pixel writes, the window search and result delivery
// ----------------------------------------------------------------------------
`include "knn_patch_block_matcher_unit_macros.svh"
module kpm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic           i_func,
    output logic           o_wr_en,
    output logic           o_valid,
    input  logic           i_stall,
    output kpm_pkg::t_cmd  o_cmd,
    input  kpm_pkg::t_sts  i_sts
);
    import kpm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_ACC = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_INS = 3'd4;
    localparam logic [2:0] ST_OUT = 3'd5;
    localparam logic [2:0] ST_LAST = 3'd6;

    logic [2:0] r_state, n_state;
    logic accept;

    assign o_stall = (r_state != ST_IDLE);
    assign accept = i_valid && !o_stall;
    assign o_wr_en = accept && (i_func == FUNC_WRITE);
    assign o_valid = (r_state == ST_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_func == FUNC_QUERY) begin
                    o_cmd.clear = 1'b1;
                    o_cmd.load_win = 1'b1;
                    o_cmd.out_load = 1'b1;
                    if (i_sts.valid_ref && !i_sts.win_empty) begin
                        n_state = ST_FETCH;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_FETCH: begin
                o_cmd.step_pix = 1'b1;
                n_state = i_sts.pix_last ? ST_LAST : ST_ACC;
            end
            ST_ACC: begin
                o_cmd.step_pix = 1'b1;
                o_cmd.acc_en = 1'b1;
                if (i_sts.pix_last) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                o_cmd.acc_en = 1'b1;
                n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (i_sts.ins_skip) begin
                    o_cmd.next_cand = 1'b1;
                    o_cmd.first_pix = 1'b1;
                    n_state = i_sts.cand_last ? ST_OUT : ST_FETCH;
                end else begin
                    o_cmd.ins_check = 1'b1;
                    n_state = ST_INS;
                end
            end
            ST_INS: begin
                o_cmd.ins_step = 1'b1;
                if (i_sts.ins_done) begin
                    o_cmd.next_cand = 1'b1;
                    o_cmd.first_pix = 1'b1;
                    n_state = i_sts.cand_last ? ST_OUT : ST_FETCH;
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    o_cmd.out_next = 1'b1;
                    if (i_sts.out_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `KPM_ASSERT_IMP(a_out_only_busy, o_valid, o_stall, "result shown while idle")
    `KPM_ASSERT_IMP(a_query_leaves_idle, accept && i_func == FUNC_QUERY,
        ##1 r_state != ST_IDLE, "query did not start")
    `KPM_ASSERT_IMP(a_write_stays_idle, o_wr_en, ##1 r_state == ST_IDLE, "write left idle")
endmodule
